/* sv/gray_interleave_order_top_assert.svh */
// Assertion macros for the gray interleave order block.
// Used by the port checker; needs nothing else.
`ifndef GRAY_INTERLEAVE_ORDER_TOP_ASSERT_SVH
`define GRAY_INTERLEAVE_ORDER_TOP_ASSERT_SVH

// same-cycle implication
`define GIO_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gio port check failed");

// next-cycle implication
`define GIO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gio port check failed");

`endif

/* sv/gio_pkg.sv */
// Shared types and constants for the gray interleave order block.
// No dependencies.
`default_nettype none

package gio_pkg;

  localparam int WORD_BITS    = 32;
  localparam int MAX_DIMS_DEF = 16;
  localparam int DIMS_W       = 5;
  localparam int IDX_W        = 4;
  localparam int PLANE_W      = $clog2(WORD_BITS);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_EMIT,
    ST_DRAIN
  } gio_state_t;

  // one key bit in flight between the store read and the serial decoder
  typedef struct packed {
    logic               valid;
    logic [PLANE_W-1:0] plane;
  } gio_bit_t;

  // finished key word from the serial decoder
  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] word;
    logic [IDX_W-1:0]     idx;
    logic                 last;
  } gio_word_t;

  function automatic logic [WORD_BITS-1:0] to_gray(input logic [WORD_BITS-1:0] v);
    return v ^ (v >> 1);
  endfunction

endpackage

`default_nettype wire

/* sv/gio_coord_if.sv */
// Coordinate input channel: valid/ready plus one coordinate.
// Depends on gio_pkg.
`default_nettype none

interface gio_coord_if;
  logic                          valid;
  logic                          ready;
  logic [gio_pkg::WORD_BITS-1:0] coord;

  modport source (output valid, output coord, input ready);
  modport sink (input valid, input coord, output ready);
endinterface

`default_nettype wire

/* sv/gio_key_if.sv */
// Key word output channel: valid/ready plus word, index and last flag.
// Depends on gio_pkg.
`default_nettype none

interface gio_key_if;
  logic                          valid;
  logic                          ready;
  logic [gio_pkg::WORD_BITS-1:0] key_word;
  logic [gio_pkg::IDX_W-1:0]     word_index;
  logic                          last_word;

  modport source (output valid, output key_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input key_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

/* sv/gio_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gio_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sv/gio_seq.sv */
// Sequencer: stores coordinates, then walks the store one key bit per cycle
// while go is high (plane by plane, coordinate by coordinate). Uses gio_pkg.
`default_nettype none

module gio_seq #(
  parameter int MAX_DIMS = gio_pkg::MAX_DIMS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [gio_pkg::DIMS_W-1:0]    cfg_wdata,
  input  wire logic                          in_fire,
  input  wire logic [gio_pkg::WORD_BITS-1:0] coord,
  input  wire logic                          go,
  input  wire logic                          point_done,
  output logic                               in_ready,
  output logic [gio_pkg::DIMS_W-1:0]         eff_dims,
  output logic                               ram_we,
  output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] ram_waddr,
  output logic [gio_pkg::WORD_BITS-1:0]      ram_wdata,
  output logic                               ram_re,
  output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] ram_raddr,
  output gio_pkg::gio_bit_t                  bit_ctl
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int DW = gio_pkg::DIMS_W;
  localparam int PW = gio_pkg::PLANE_W;

  gio_pkg::gio_state_t state, state_next;
  logic [DW-1:0]       dims;
  logic [DW-1:0]       cnt, cnt_next;
  logic [PW-1:0]       plane, plane_next;
  gio_pkg::gio_bit_t   bit_next;
  logic [AW+DW-1:0]    addr_ext;
  logic                cnt_at_end;

  // clamp the dimension count to 1..MAX_DIMS
  always_comb begin
    if (dims == '0) begin
      eff_dims = DW'(1);
    end else if (32'(dims) > MAX_DIMS) begin
      eff_dims = DW'(MAX_DIMS);
    end else begin
      eff_dims = dims;
    end
  end

  assign addr_ext   = {AW'(0), cnt};
  assign cnt_at_end = (cnt == eff_dims - DW'(1));
  assign ram_waddr  = addr_ext[AW-1:0];
  assign ram_raddr  = addr_ext[AW-1:0];
  assign ram_wdata  = gio_pkg::to_gray(coord);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gio_pkg::ST_COLLECT;
      dims    <= DW'(1);
      cnt     <= '0;
      plane   <= '0;
      bit_ctl <= '0;
    end else begin
      state   <= state_next;
      plane   <= plane_next;
      bit_ctl <= bit_next;
      if (cfg_we) begin
        dims <= cfg_wdata;
        cnt  <= '0;  // drop any partial point
      end else begin
        cnt <= cnt_next;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    plane_next = plane;
    bit_next   = bit_ctl;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    case (state)
      gio_pkg::ST_COLLECT: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ram_we = 1'b1;
          if (cnt_at_end) begin
            cnt_next   = '0;
            plane_next = '0;
            state_next = gio_pkg::ST_EMIT;
          end else begin
            cnt_next = cnt + DW'(1);
          end
        end
      end
      gio_pkg::ST_EMIT: begin
        if (go) begin
          ram_re         = 1'b1;
          bit_next.valid = 1'b1;
          bit_next.plane = plane;
          if (cnt_at_end) begin
            cnt_next = '0;
            if (plane == PW'(gio_pkg::WORD_BITS - 1)) begin
              state_next = gio_pkg::ST_DRAIN;
            end else begin
              plane_next = plane + PW'(1);
            end
          end else begin
            cnt_next = cnt + DW'(1);
          end
        end
      end
      gio_pkg::ST_DRAIN: begin
        if (go) begin
          bit_next.valid = 1'b0;
        end
        if (point_done) begin
          state_next = gio_pkg::ST_COLLECT;
        end
      end
      default: begin
        state_next = gio_pkg::ST_COLLECT;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/gio_serdec.sv */
// Serial Gray decoder: takes one key bit per cycle when go is high,
// runs the prefix XOR in each word, packs it MSB first. Uses gio_pkg.
`default_nettype none

module gio_serdec (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire gio_pkg::gio_bit_t             bit_ctl,
  input  wire logic [gio_pkg::WORD_BITS-1:0] rdata,
  input  wire logic [gio_pkg::DIMS_W-1:0]    eff_dims,
  output gio_pkg::gio_word_t                 word_out
);

  localparam int WB = gio_pkg::WORD_BITS;
  localparam int PW = gio_pkg::PLANE_W;
  localparam int DW = gio_pkg::DIMS_W;

  logic [WB-1:0] shreg;
  logic [WB-1:0] shreg_next;
  logic [PW-1:0] ofs;
  logic [DW-1:0] wcnt;
  logic [PW-1:0] bit_sel;
  logic          key_bit;
  logic          dec_bit;
  logic          step;
  logic          word_end;

  assign step     = go && bit_ctl.valid;
  assign bit_sel  = PW'(WB - 1) - bit_ctl.plane;
  assign key_bit  = rdata[bit_sel];
  // prefix XOR restarts at the top of every word
  assign dec_bit  = key_bit ^ ((ofs == '0) ? 1'b0 : shreg[0]);
  assign shreg_next = {shreg[WB-2:0], dec_bit};
  assign word_end = (ofs == PW'(WB - 1));

  always_comb begin
    word_out.valid = step && word_end;
    word_out.word  = shreg_next;
    word_out.idx   = wcnt[gio_pkg::IDX_W-1:0];
    word_out.last  = (wcnt == eff_dims - DW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs  <= '0;
      wcnt <= '0;
    end else if (step) begin
      if (word_end) begin
        ofs  <= '0;
        wcnt <= word_out.last ? '0 : wcnt + DW'(1);
      end else begin
        ofs <= ofs + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      shreg <= shreg_next;
    end
  end

endmodule

`default_nettype wire

/* sv/gray_interleave_order_top.sv */
// Gray-code ordering key: coordinate store, bit-serial interleave and decode.
// Depends on gio_pkg, gio_coord_if, gio_key_if, gio_ram, gio_seq, gio_serdec.
//
// Usage:
//   coords: one 32-bit coordinate per transaction, dims transactions per point.
//   keys:   dims transactions per point, key_word with word_index 0 first,
//           last_word set on the final one.
//   cfg_we/cfg_wdata: writes dims (0 acts as 1, above MAX_DIMS acts as
//           MAX_DIMS); a write drops a partially received point. Write only
//           while idle.
// Timing:
//   Each coordinate is stored as it is taken. After the last coordinate of a
//   point, the key is produced one bit per cycle through the single store
//   read port and the serial decoder, holding while the output stalls.
//   coords.ready is low while a key is built.
// Reset (rst, synchronous): dims = 1, no partial point, output empty.
// Stall: a finished word waits in the output register; while it is not taken
//   the bit-serial walk holds, and resumes once keys.ready is seen.
`default_nettype none

module gray_interleave_order_top #(
  parameter int MAX_DIMS = gio_pkg::MAX_DIMS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [gio_pkg::DIMS_W-1:0] cfg_wdata,
  gio_coord_if.sink                       coords,
  gio_key_if.source                       keys
);

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic                          go;
  logic                          in_fire;
  logic                          in_ready;
  logic [gio_pkg::DIMS_W-1:0]    eff_dims;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [gio_pkg::WORD_BITS-1:0] ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [gio_pkg::WORD_BITS-1:0] ram_rdata;
  gio_pkg::gio_bit_t             bit_ctl;
  gio_pkg::gio_word_t            word_out;
  logic                          out_valid;
  logic [gio_pkg::WORD_BITS-1:0] out_word;
  logic [gio_pkg::IDX_W-1:0]     out_idx;
  logic                          out_last;

  // the walk advances only when the output register can take a word
  assign go      = !out_valid || keys.ready;
  assign in_fire = coords.valid && in_ready;

  assign coords.ready    = in_ready;
  assign keys.valid      = out_valid;
  assign keys.key_word   = out_word;
  assign keys.word_index = out_idx;
  assign keys.last_word  = out_last;

  gio_seq #(
    .MAX_DIMS (MAX_DIMS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_fire    (in_fire),
    .coord      (coords.coord),
    .go         (go),
    .point_done (word_out.valid && word_out.last),
    .in_ready   (in_ready),
    .eff_dims   (eff_dims),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .bit_ctl    (bit_ctl)
  );

  gio_ram #(
    .WIDTH (gio_pkg::WORD_BITS),
    .DEPTH (MAX_DIMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gio_serdec u_serdec (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .bit_ctl  (bit_ctl),
    .rdata    (ram_rdata),
    .eff_dims (eff_dims),
    .word_out (word_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && word_out.valid) begin
      out_valid <= 1'b1;
    end else if (keys.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && word_out.valid) begin
      out_word <= word_out.word;
      out_idx  <= word_out.idx;
      out_last <= word_out.last;
    end
  end

endmodule

`default_nettype wire

/* sv/gio_checker.sv */
// Port-level checks for gray_interleave_order_top, attached by bind.
// Depends on gray_interleave_order_top_assert.svh and gio_pkg.
`default_nettype none

`include "gray_interleave_order_top_assert.svh"

module gio_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [gio_pkg::WORD_BITS-1:0] out_word,
  input wire logic [gio_pkg::IDX_W-1:0]     out_index,
  input wire logic                          out_last
);

  // input side closes only right after a coordinate transaction
  `GIO_ASSERT_NOW(a_ready_fall, clk, rst, $fell(in_ready), $past(in_valid && in_ready))

  // while a non-final word is pending the key is still being built
  `GIO_ASSERT_NOW(a_busy_mid_key, clk, rst, out_valid && !out_last, !in_ready)

  // a stalled word holds
  `GIO_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_word) && $stable(out_index) && $stable(out_last))

endmodule

bind gray_interleave_order_top gio_checker u_gio_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (coords.valid),
  .in_ready  (coords.ready),
  .out_valid (keys.valid),
  .out_ready (keys.ready),
  .out_word  (keys.key_word),
  .out_index (keys.word_index),
  .out_last  (keys.last_word)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for gray_interleave_order_top: Gray-coded interleave key words.
// Needs gio_pkg, gio_coord_if, gio_key_if and the block's RTL; drives both channels
// with random gaps and checks every key word against an in-bench predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int WORD_BITS      = gio_pkg::WORD_BITS;
  localparam int IDX_W          = gio_pkg::IDX_W;
  localparam int DIMS_W         = gio_pkg::DIMS_W;
  localparam int MAX_DIMS_DEF   = gio_pkg::MAX_DIMS_DEF;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET    = 410;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [WORD_BITS-1:0] key;
    logic [IDX_W-1:0]     pos;
    logic                 last_flag;
  } key_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [DIMS_W-1:0] cfg_wdata;

  gio_coord_if coord_bus();
  gio_key_if   key_bus();

  gray_interleave_order_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .coords    (coord_bus),
    .keys      (key_bus)
  );

  // predictor state
  key_word_t            expected_keys[$];
  logic [WORD_BITS-1:0] gray_store [MAX_DIMS_DEF];
  int unsigned          coord_count;
  logic [DIMS_W-1:0]    dims_reg;

  int unsigned coords_sent;
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned active_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > MAX_DIMS_DEF) return MAX_DIMS_DEF;
    return 32'(dims_reg);
  endfunction

  // Store one coordinate; on the last one of a point, queue the whole key.
  function automatic void predict_key(input logic [WORD_BITS-1:0] c);
    int unsigned          d;
    int unsigned          p;
    logic [WORD_BITS-1:0] words [MAX_DIMS_DEF];
    logic [WORD_BITS-1:0] y;
    key_word_t            kw;
    d = active_dims();
    if (coord_count >= d) coord_count = 0;
    gray_store[coord_count] = c ^ (c >> 1);
    coord_count++;
    if (coord_count < d) return;
    coord_count = 0;
    for (int k = 0; k < d; k++) words[k] = '0;
    // bit planes from the top, every coordinate in order, packed MSB-first
    for (int plane = 0; plane < WORD_BITS; plane++) begin
      for (int di = 0; di < d; di++) begin
        p = plane * d + di;
        words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)] =
          gray_store[di][WORD_BITS - 1 - plane];
      end
    end
    for (int k = 0; k < d; k++) begin
      // prefix XOR from the MSB down
      y = words[k];
      for (int b = WORD_BITS - 2; b >= 0; b--) y[b] = y[b + 1] ^ words[k][b];
      kw.key       = y;
      kw.pos       = k[IDX_W-1:0];
      kw.last_flag = (k == d - 1);
      expected_keys.push_back(kw);
    end
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_coord();
    int unsigned sh;
    sh = $urandom_range(0, WORD_BITS - 1);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << sh;
      3: return ~(32'h1 << sh);
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic void log_mismatch(input string field, input logic [WORD_BITS-1:0] want,
                                       input logic [WORD_BITS-1:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("key mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  // All tasks start and end at a falling edge.
  task automatic send_coord(input logic [WORD_BITS-1:0] value);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      coord_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    coord_bus.valid <= 1'b1;
    coord_bus.coord <= value;
    do @(posedge clk); while (coord_bus.ready !== 1'b1);
    predict_key(value);
    coords_sent++;
    @(negedge clk);
  endtask

  task automatic write_dims(input logic [DIMS_W-1:0] value);
    coord_bus.valid <= 1'b0;
    while (expected_keys.size() != 0) @(negedge clk);
    // a partial point may still be landing in the store
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we      <= 1'b0;
    dims_reg    = value;
    coord_count = 0;
  endtask

  task automatic test_reset_dims();
    send_coord(32'h0000_0000);
    send_coord(32'hFFFF_FFFF);
    send_coord(32'hAAAA_AAAA);
    send_coord(32'h8000_0000);
  endtask

  task automatic test_dims_zero();
    write_dims(5'd0);
    send_coord(32'h5555_5555);
    send_coord(32'h0000_0001);
  endtask

  task automatic test_partial_point_dropped();
    write_dims(5'd3);
    send_coord(32'hDEAD_BEEF);
    send_coord(32'h1234_5678);
    write_dims(5'd2);
    send_coord(32'hFFFF_FFFF);
    send_coord(32'h0000_0000);
  endtask

  task automatic test_dims_above_max();
    write_dims(5'd31);
    repeat (MAX_DIMS_DEF) send_coord(rand_coord());
  endtask

  task automatic test_output_backpressure();
    write_dims(5'd1);
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_coord(rand_coord());
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_points();
    int unsigned       phase;
    int unsigned       d;
    logic [DIMS_W-1:0] setting;
    phase = 0;
    while (coords_sent < ITEM_TARGET) begin
      case (phase)
        0: setting = 5'd16;
        1: setting = 5'd1;
        2: setting = 5'd17;
        3: setting = 5'd0;
        4: setting = 5'd31;
        5: setting = 5'd2;
        default: begin
          if ($urandom_range(0, 4) != 0) setting = DIMS_W'($urandom_range(1, 4));
          else setting = DIMS_W'($urandom_range(0, 31));
        end
      endcase
      write_dims(setting);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      d = active_dims();
      repeat ($urandom_range(1, 6) * d) send_coord(rand_coord());
      // occasionally leave a point unfinished; the next write drops it
      if (d > 1 && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, d - 1)) send_coord(rand_coord());
      phase++;
    end
  endtask

  // key sink: random gaps per transaction, one long hold when requested
  initial begin : key_sink
    int unsigned gap;
    key_bus.ready = 1'b0;
    do @(negedge clk); while (rst !== 1'b0);
    forever begin
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap != 0) begin
        key_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      key_bus.ready <= 1'b1;
      do @(posedge clk); while (key_bus.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : key_check
    key_word_t want;
    if (!rst) begin
      if (key_bus.valid === 1'b1 && key_bus.ready === 1'b1) begin
        if (expected_keys.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected key word %h index %0d last %b",
                     key_bus.key_word, key_bus.word_index, key_bus.last_word);
        end else begin
          want = expected_keys.pop_front();
          if (key_bus.key_word !== want.key)
            log_mismatch("key_word", want.key, key_bus.key_word);
          if (key_bus.word_index !== want.pos)
            log_mismatch("word_index", want.pos, key_bus.word_index);
          if (key_bus.last_word !== want.last_flag)
            log_mismatch("last_word", want.last_flag, key_bus.last_word);
        end
      end
      if ((coord_bus.valid === 1'b1 && coord_bus.ready === 1'b1) ||
          (key_bus.valid === 1'b1 && key_bus.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    coord_bus.valid = 1'b0;
    coord_bus.coord = '0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    hold_req        = 1'b0;
    dims_reg        = 5'd1;
    coord_count     = 0;
    coords_sent     = 0;
    fail_count      = 0;
    idle_cycles     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_dims();
    test_dims_zero();
    test_partial_point_dropped();
    test_dims_above_max();
    test_output_backpressure();
    test_random_points();

    coord_bus.valid <= 1'b0;
    while (expected_keys.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_keys.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
